// ===== rtl/core/mcit_pkg.sv =====
// shared constants, codes and types for the multi-channel interval timer
// no dependencies
`timescale 1ns / 1ps

package mcit_pkg;

   localparam int TIMER_COUNT = 8;
   localparam int POOL_SLOTS  = (TIMER_COUNT < 8) ? TIMER_COUNT : 8;
   localparam int ADDR_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int SLOT_W      = 3;

   localparam logic [2:0] REQ_TICK      = 3'd0;
   localparam logic [2:0] REQ_START     = 3'd1;
   localparam logic [2:0] REQ_STOP      = 3'd2;
   localparam logic [2:0] REQ_SET_DUR   = 3'd3;
   localparam logic [2:0] REQ_SET_RELOAD = 3'd4;
   localparam logic [2:0] REQ_SET_TAG   = 3'd5;
   localparam logic [2:0] REQ_RESTART   = 3'd6;
   localparam logic [2:0] REQ_QUERY     = 3'd7;

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_BAD_HANDLE   = 2'd1;
   localparam logic [1:0] STATUS_BAD_INTERVAL = 2'd2;
   localparam logic [1:0] STATUS_NO_RESOURCE  = 2'd3;

   localparam logic KIND_RESPONSE = 1'b0;
   localparam logic KIND_EXPIRY   = 1'b1;

   typedef struct packed {
      logic [31:0] start_time;
      logic [31:0] interval;
      logic        reload;
      logic [31:0] tag;
   } entry_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      entry_type         wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } ram_ctrl_type;

   typedef struct packed {
      logic              kind;
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot;
      logic [31:0]       tag_out;
      logic [31:0]       duration_out;
      logic [31:0]       remaining;
      logic [31:0]       elapsed;
      logic              reload_out;
      logic              last;
   } rsp_type;

endpackage

// ===== rtl/core/mcit_req_if.sv =====
// request channel of the interval timer: valid, ready and the request fields
// no dependencies
`timescale 1ns / 1ps

interface mcit_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [2:0]  timer_index;
   logic [31:0] duration;
   logic        auto_reload;
   logic        reset_now;
   logic [31:0] user_tag;

   modport source (output valid, req_type, timer_index, duration, auto_reload,
                   reset_now, user_tag, input ready);
   modport sink (input valid, req_type, timer_index, duration, auto_reload,
                 reset_now, user_tag, output ready);
endinterface

// ===== rtl/core/mcit_rsp_if.sv =====
// result channel of the interval timer: valid, ready and the result fields
// no dependencies
`timescale 1ns / 1ps

interface mcit_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [1:0]  status;
   logic [2:0]  slot;
   logic [31:0] tag_out;
   logic [31:0] duration_out;
   logic [31:0] remaining;
   logic [31:0] elapsed;
   logic        reload_out;
   logic        last;

   modport source (output valid, kind, status, slot, tag_out, duration_out,
                   remaining, elapsed, reload_out, last, input ready);
   modport sink (input valid, kind, status, slot, tag_out, duration_out,
                 remaining, elapsed, reload_out, last, output ready);
endinterface

// ===== rtl/core/mcit_entry_ram.sv =====
// per-slot timer entry memory, one write and one registered read port
// depends on mcit_pkg
`timescale 1ns / 1ps

module mcit_entry_ram (
   input  logic                  clock,
   input  mcit_pkg::ram_ctrl_type ctrl,
   output mcit_pkg::entry_type   rd_data
);

   mcit_pkg::entry_type mem [mcit_pkg::POOL_SLOTS];
   mcit_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/mcit_rsp_reg.sv =====
// output register of the result channel
// depends on mcit_pkg and mcit_rsp_if
`timescale 1ns / 1ps

module mcit_rsp_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mcit_pkg::rsp_type push_data,
   output logic              out_free,
   mcit_rsp_if.source        rsp_chan
);

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   mcit_pkg::rsp_type rsp_data_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_data_ff <= push_data;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.kind         = rsp_data_ff.kind;
   assign rsp_chan.status       = rsp_data_ff.status;
   assign rsp_chan.slot         = rsp_data_ff.slot;
   assign rsp_chan.tag_out      = rsp_data_ff.tag_out;
   assign rsp_chan.duration_out = rsp_data_ff.duration_out;
   assign rsp_chan.remaining    = rsp_data_ff.remaining;
   assign rsp_chan.elapsed      = rsp_data_ff.elapsed;
   assign rsp_chan.reload_out   = rsp_data_ff.reload_out;
   assign rsp_chan.last         = rsp_data_ff.last;

endmodule

// ===== rtl/core/multi_channel_interval_timer_top.sv =====
// interval timer pool: sequencer, slot activity bits, counter and limit register
// a command result is registered in the output register once the result channel has room
// a tick scans the slots in order, one memory read per slot, then flushes the held
// expiry; a scan or a command waits while the result channel stalls
// reset clears the counter, activity bits and sequencer and sets max_duration
// to all ones; the entry memory is not cleared
`timescale 1ns / 1ps

module multi_channel_interval_timer_top (
   input  logic        clock,
   input  logic        reset,
   mcit_req_if.sink    req_chan,
   mcit_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CMD   = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_FLUSH = 3'd3;
   localparam logic [2:0] S_RESP  = 3'd4;

   localparam int AW = mcit_pkg::ADDR_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(mcit_pkg::POOL_SLOTS - 1);

   logic [2:0]                    state_ff, state_in;
   logic [31:0]                   now_ff, now_in;
   logic [31:0]                   max_dur_ff;
   logic [mcit_pkg::POOL_SLOTS-1:0] active_ff, active_in;
   logic [AW-1:0]                 scan_ff, scan_in;
   logic                          pend_valid_ff, pend_valid_in;
   logic [mcit_pkg::SLOT_W-1:0]   pend_slot_ff, pend_slot_in;
   logic [31:0]                   pend_tag_ff, pend_tag_in;
   mcit_pkg::rsp_type             resp_ff, resp_in;

   logic [2:0]                    op_ff;
   logic [AW-1:0]                 addr_ff;
   logic [mcit_pkg::SLOT_W-1:0]   slot_ff;
   logic [31:0]                   dur_ff;
   logic                          rel_ff;
   logic                          rnow_ff;
   logic [31:0]                   tag_ff;

   mcit_pkg::ram_ctrl_type        ram_ctrl;
   mcit_pkg::entry_type           rd_entry;
   mcit_pkg::entry_type           wb_entry;
   mcit_pkg::rsp_type             push_data;
   logic                          push;
   logic                          out_free;

   logic                          req_xfer;
   logic [AW-1:0]                 req_addr;
   logic                          idx_ok;
   logic                          free_found;
   logic [AW-1:0]                 free_addr;
   logic [31:0]                   el;
   logic [31:0]                   rem;
   logic                          expire;

   mcit_entry_ram u_ram (
      .clock   (clock),
      .ctrl    (ram_ctrl),
      .rd_data (rd_entry)
   );

   mcit_rsp_reg u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .out_free  (out_free),
      .rsp_chan  (rsp_chan)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign req_addr       = req_chan.timer_index[AW-1:0];
   assign idx_ok         = ({1'b0, req_chan.timer_index} < 4'(mcit_pkg::POOL_SLOTS))
                           && active_ff[req_addr];

   always_comb begin
      free_found = 1'b0;
      free_addr  = '0;
      for (int i = mcit_pkg::POOL_SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            free_found = 1'b1;
            free_addr  = AW'(i);
         end
      end
   end

   // elapsed and remaining of the entry just read
   assign el     = now_ff - rd_entry.start_time;
   assign rem    = rd_entry.interval - el;
   assign expire = active_ff[scan_ff] && (rd_entry.interval < el);

   always_comb begin
      state_in      = state_ff;
      now_in        = now_ff;
      active_in     = active_ff;
      scan_in       = scan_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      pend_tag_in   = pend_tag_ff;
      resp_in       = resp_ff;
      ram_ctrl      = '0;
      wb_entry      = rd_entry;
      push          = 1'b0;
      push_data     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               resp_in        = '0;
               resp_in.kind   = mcit_pkg::KIND_RESPONSE;
               resp_in.last   = 1'b1;
               state_in       = S_RESP;
               if (req_chan.req_type == mcit_pkg::REQ_TICK) begin
                  now_in           = now_ff + 32'd1;
                  scan_in          = '0;
                  ram_ctrl.rd_en   = 1'b1;
                  ram_ctrl.rd_addr = '0;
                  state_in         = S_SCAN;
               end else if (req_chan.req_type == mcit_pkg::REQ_START) begin
                  if (req_chan.duration > max_dur_ff) begin
                     resp_in.status = mcit_pkg::STATUS_BAD_INTERVAL;
                  end else if (free_found) begin
                     ram_ctrl.wr_en              = 1'b1;
                     ram_ctrl.wr_addr            = free_addr;
                     ram_ctrl.wr_data.start_time = now_ff;
                     ram_ctrl.wr_data.interval   = req_chan.duration;
                     ram_ctrl.wr_data.reload     = req_chan.auto_reload;
                     ram_ctrl.wr_data.tag        = req_chan.user_tag;
                     active_in[free_addr]        = 1'b1;
                     resp_in.status              = mcit_pkg::STATUS_OK;
                     resp_in.slot                = mcit_pkg::SLOT_W'(free_addr);
                  end else begin
                     resp_in.status = mcit_pkg::STATUS_NO_RESOURCE;
                  end
               end else begin
                  resp_in.slot = req_chan.timer_index;
                  if (!idx_ok) begin
                     resp_in.status = mcit_pkg::STATUS_BAD_HANDLE;
                  end else if (req_chan.req_type == mcit_pkg::REQ_STOP) begin
                     active_in[req_addr] = 1'b0;
                     resp_in.status      = mcit_pkg::STATUS_OK;
                  end else begin
                     ram_ctrl.rd_en   = 1'b1;
                     ram_ctrl.rd_addr = req_addr;
                     state_in         = S_CMD;
                  end
               end
            end
         end

         // read-modify-write of the addressed entry; a query only reads it
         S_CMD: begin
            if (out_free) begin
               push           = 1'b1;
               push_data.kind = mcit_pkg::KIND_RESPONSE;
               push_data.slot = slot_ff;
               push_data.last = 1'b1;
               state_in       = S_IDLE;
               ram_ctrl.wr_addr = addr_ff;
               unique case (op_ff)
                  mcit_pkg::REQ_SET_DUR: begin
                     if (dur_ff > max_dur_ff) begin
                        push_data.status = mcit_pkg::STATUS_BAD_INTERVAL;
                     end else begin
                        wb_entry.interval = dur_ff;
                        if (rnow_ff) begin
                           wb_entry.start_time = now_ff;
                        end
                        ram_ctrl.wr_en = 1'b1;
                     end
                  end
                  mcit_pkg::REQ_SET_RELOAD: begin
                     wb_entry.reload = rel_ff;
                     ram_ctrl.wr_en  = 1'b1;
                  end
                  mcit_pkg::REQ_SET_TAG: begin
                     wb_entry.tag   = tag_ff;
                     ram_ctrl.wr_en = 1'b1;
                  end
                  mcit_pkg::REQ_RESTART: begin
                     wb_entry.start_time = now_ff;
                     ram_ctrl.wr_en      = 1'b1;
                  end
                  mcit_pkg::REQ_QUERY: begin
                     push_data.tag_out      = rd_entry.tag;
                     push_data.duration_out = rd_entry.interval;
                     push_data.remaining    = rem;
                     push_data.elapsed      = el;
                     push_data.reload_out   = rd_entry.reload;
                  end
                  default: begin
                  end
               endcase
               ram_ctrl.wr_data = wb_entry;
            end
         end

         // one slot per cycle unless a held expiry cannot be pushed; an expiry is held back until the next is known
         S_SCAN: begin
            if (!(expire && pend_valid_ff && !out_free)) begin
               if (expire) begin
                  if (pend_valid_ff) begin
                     push              = 1'b1;
                     push_data.kind    = mcit_pkg::KIND_EXPIRY;
                     push_data.slot    = pend_slot_ff;
                     push_data.tag_out = pend_tag_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_slot_in  = mcit_pkg::SLOT_W'(scan_ff);
                  pend_tag_in   = rd_entry.tag;
                  if (rd_entry.reload) begin
                     wb_entry.start_time = now_ff;
                     ram_ctrl.wr_en      = 1'b1;
                     ram_ctrl.wr_addr    = scan_ff;
                     ram_ctrl.wr_data    = wb_entry;
                  end else begin
                     active_in[scan_ff] = 1'b0;
                  end
               end
               if (scan_ff == LAST_ADDR) begin
                  state_in = S_FLUSH;
               end else begin
                  scan_in          = scan_ff + 1'b1;
                  ram_ctrl.rd_en   = 1'b1;
                  ram_ctrl.rd_addr = scan_ff + 1'b1;
               end
            end
         end

         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               push              = 1'b1;
               push_data.kind    = mcit_pkg::KIND_EXPIRY;
               push_data.slot    = pend_slot_ff;
               push_data.tag_out = pend_tag_ff;
               push_data.last    = 1'b1;
               pend_valid_in     = 1'b0;
               state_in          = S_IDLE;
            end
         end

         S_RESP: begin
            if (out_free) begin
               push      = 1'b1;
               push_data = resp_ff;
               state_in  = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         now_ff        <= '0;
         max_dur_ff    <= '1;
         active_ff     <= '0;
         scan_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         active_ff     <= active_in;
         scan_ff       <= scan_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_wr_en) begin
            max_dur_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      pend_tag_ff  <= pend_tag_in;
      resp_ff      <= resp_in;
      if (req_xfer) begin
         op_ff   <= req_chan.req_type;
         addr_ff <= req_addr;
         slot_ff <= req_chan.timer_index;
         dur_ff  <= req_chan.duration;
         rel_ff  <= req_chan.auto_reload;
         rnow_ff <= req_chan.reset_now;
         tag_ff  <= req_chan.user_tag;
      end
   end

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !pend_valid_ff)
      else $error("held expiry left over after scan");

   a_tick_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && req_chan.req_type == mcit_pkg::REQ_TICK) |=>
      (state_ff == S_SCAN && scan_ff == '0))
      else $error("tick transfer did not start a scan at slot zero");

   a_scan_not_last: assert property (@(posedge clock) disable iff (reset)
      (push && state_ff == S_SCAN) |-> (!push_data.last && push_data.kind))
      else $error("expiry pushed mid-scan marked last or not an expiry");

   a_write_no_read_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_ctrl.wr_en && ram_ctrl.rd_en) |-> (ram_ctrl.wr_addr != ram_ctrl.rd_addr))
      else $error("entry memory read and written at the same slot");

endmodule
